@@ rtl/core/text_console_writer_defines.svh @@
// ----------------------------------------------------------------------------
// text_console_writer_defines.svh
// Assertion macros shared by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Field widths, op codes and transaction payload types of the console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int unsigned COL_FW  = 7;
    localparam int unsigned ROW_FW  = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CELL_W  = 16;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SETCUR = 2'd2,
        OP_READ   = 2'd3
    } tcw_op_t;

    typedef struct packed {
        tcw_op_t             op;
        logic [COL_FW-1:0]   col_in;
        logic [ROW_FW-1:0]   row_in;
        logic [BYTE_W-1:0]   char_code;
        logic [BYTE_W-1:0]   attribute;
    } tcw_in_t;

    typedef struct packed {
        logic [COL_FW-1:0]   cursor_col;
        logic [ROW_FW-1:0]   cursor_row;
        logic [BYTE_W-1:0]   cell_char;
        logic [BYTE_W-1:0]   cell_attrib;
    } tcw_out_t;

endpackage

`default_nettype wire

@@ rtl/core/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tcw_addr.sv @@
// ----------------------------------------------------------------------------
// tcw_addr
// Maps a logical column/row to a RAM address through the rotating top row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_addr #(
    parameter int unsigned COLS = 80,
    parameter int unsigned ROWS = 25,
    localparam int unsigned CW = $clog2(COLS),
    localparam int unsigned RW = $clog2(ROWS),
    localparam int unsigned AW = $clog2(COLS * ROWS)
) (
    input  wire logic [CW-1:0] col,
    input  wire logic [RW-1:0] row,
    input  wire logic [RW-1:0] top,
    output logic      [AW-1:0] addr
);

    localparam logic [RW:0]   ROWS_W = (RW + 1)'(ROWS);
    localparam logic [AW-1:0] COLS_A = AW'(COLS);

    logic [RW:0]   row_sum;
    logic [RW-1:0] phys_row;

    // physical row = (row + top) mod ROWS, both operands below ROWS
    always_comb begin
        row_sum = {1'b0, row} + {1'b0, top};
        if (row_sum >= ROWS_W) begin
            row_sum = row_sum - ROWS_W;
        end
        phys_row = row_sum[RW-1:0];
        addr     = AW'(AW'(phys_row) * COLS_A + AW'(col));
    end

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen engine: cell store, cursor, eager wrap and scroll-up.
// ----------------------------------------------------------------------------
//   channel  | ports                         | payload
//   ---------+-------------------------------+-----------
//   input    | s_valid / s_ready / s_data    | tcw_in_t
//   result   | m_valid / m_ready / m_data    | tcw_out_t
//
// Every op is accepted in S_IDLE, which touches the cell RAM; S_PUSH then loads
// the output register (for a read, the RAM's registered data lands there).
// A scroll runs S_SCROLL in between: rows rotate via a top-row pointer, so only
// the recycled row is blanked, one cell per cycle. After reset a clearing pass
// blanks all COLS*ROWS cells, one per cycle, before the first transaction.
// A stalled result holds the push state; the next transaction is taken once
// the result has moved into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int unsigned COLS = 80,
    parameter int unsigned ROWS = 25
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tcw_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tcw_out_t      m_data
);

    localparam int unsigned CW    = $clog2(COLS);
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned DEPTH = COLS * ROWS;
    localparam int unsigned AW    = $clog2(DEPTH);

    localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCROLL,
        S_PUSH
    } state_t;

    state_t        state_reg,   state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] scr_cnt_reg, scr_cnt_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [RW-1:0] top_reg,     top_next;
    logic          rd_pend_reg, rd_pend_next;
    tcw_out_t      res_reg,     res_next;
    logic          m_valid_reg, m_valid_next;
    tcw_out_t      m_data_reg,  m_data_next;

    logic              accept;
    logic [CW-1:0]     col_cl;
    logic [RW-1:0]     row_cl;
    logic              do_newline;
    logic              do_scroll;

    // cell RAM port
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    // address mapper port
    logic [CW-1:0]     map_col;
    logic [RW-1:0]     map_row;
    logic [AW-1:0]     map_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tcw_addr #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_addr (
        .col  (map_col),
        .row  (map_row),
        .top  (top_reg),
        .addr (map_addr)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // coordinates above the screen clamp to the last column / row
    always_comb begin
        col_cl = (32'(s_data.col_in) > 32'(COLS - 1)) ? COL_LAST : CW'(s_data.col_in);
        row_cl = (32'(s_data.row_in) > 32'(ROWS - 1)) ? ROW_LAST : RW'(s_data.row_in);
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        scr_cnt_next = scr_cnt_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        top_next     = top_reg;
        rd_pend_next = rd_pend_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = {s_data.attribute, s_data.char_code};
        map_col      = col_cl;
        map_row      = row_cl;
        do_newline   = 1'b0;
        do_scroll    = 1'b0;

        // output register drains independently of the FSM
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = BLANK_CELL;
                if (clr_cnt_reg == ADDR_LAST) begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            S_IDLE: begin
                if (s_data.op == OP_PUT) begin
                    map_col = cur_col_reg;
                    map_row = cur_row_reg;
                end
                if (accept) begin
                    unique case (s_data.op)
                        OP_PUT: begin
                            if (s_data.char_code == NEWLINE_CODE) begin
                                do_newline = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                if (cur_col_reg == COL_LAST) begin
                                    do_newline = 1'b1;
                                end else begin
                                    cur_col_next = CW'(cur_col_reg + CW'(1));
                                end
                            end
                        end
                        OP_WRITE: begin
                            ram_we = 1'b1;
                        end
                        OP_SETCUR: begin
                            cur_col_next = col_cl;
                            cur_row_next = row_cl;
                        end
                        OP_READ: begin
                            ram_re       = 1'b1;
                            rd_pend_next = 1'b1;
                        end
                        default: ;
                    endcase

                    if (do_newline) begin
                        cur_col_next = '0;
                        if (cur_row_reg == ROW_LAST) begin
                            do_scroll = 1'b1;
                            top_next  = (top_reg == ROW_LAST) ? '0 : RW'(top_reg + RW'(1));
                        end else begin
                            cur_row_next = RW'(cur_row_reg + RW'(1));
                        end
                    end

                    res_next.cursor_col  = COL_FW'(cur_col_next);
                    res_next.cursor_row  = ROW_FW'(cur_row_next);
                    res_next.cell_char   = '0;
                    res_next.cell_attrib = '0;
                    state_next = do_scroll ? S_SCROLL : S_PUSH;
                end
            end

            S_SCROLL: begin
                // top already advanced: the last logical row is the old top row
                map_col   = scr_cnt_reg;
                map_row   = ROW_LAST;
                ram_we    = 1'b1;
                ram_wdata = BLANK_CELL;
                if (scr_cnt_reg == COL_LAST) begin
                    scr_cnt_next = '0;
                    state_next   = S_PUSH;
                end else begin
                    scr_cnt_next = CW'(scr_cnt_reg + CW'(1));
                end
            end

            S_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    if (rd_pend_reg) begin
                        m_data_next.cell_char   = ram_rdata[BYTE_W-1:0];
                        m_data_next.cell_attrib = ram_rdata[CELL_W-1:BYTE_W];
                    end
                    rd_pend_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_CLEAR;
        endcase

        ram_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : map_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            scr_cnt_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            top_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            scr_cnt_reg <= scr_cnt_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            top_reg     <= top_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // cursor and top pointer never leave the screen
    `TCW_ASSERT_SAME(a_cursor_range, aclk, aresetn, 1'b1,
        (cur_col_reg <= COL_LAST) && (cur_row_reg <= ROW_LAST), "cursor off screen")
    `TCW_ASSERT_SAME(a_top_range, aclk, aresetn, 1'b1,
        top_reg <= ROW_LAST, "top row pointer out of range")
    // a newline on the last row starts a scroll with the cursor at column 0
    `TCW_ASSERT_NEXT(a_nl_scroll, aclk, aresetn,
        accept && (s_data.op == OP_PUT) && (s_data.char_code == NEWLINE_CODE)
            && (cur_row_reg == ROW_LAST),
        (state_reg == S_SCROLL) && (cur_col_reg == '0) && (cur_row_reg == ROW_LAST),
        "newline on last row did not scroll")
    // a read leaves its data pending for the push state
    `TCW_ASSERT_NEXT(a_read_push, aclk, aresetn,
        accept && (s_data.op == OP_READ),
        (state_reg == S_PUSH) && rd_pend_reg, "read not routed to result")

endmodule

`default_nettype wire
